[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DIP_ASSERT_IMP(name, clk, rst, lhs, rhs, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication, checked outside reset
`define DIP_ASSERT_NXT(name, clk, rst, lhs, rhs, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

[rtl/dip_pkg.sv]
package dip_pkg;

   localparam logic [63:0] ONE_C      = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] POS_INF_C  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] DEF_NAN_C  = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_C    = 64'h0008_0000_0000_0000;
   localparam logic [62:0] NEG_LIM_C  = 63'h3EB0_C6F7_A0B5_ED8D; // |-1e-6|
   localparam logic [62:0] POS_LIM_C  = 63'h3E7A_D7F2_9ABC_AF48; // 1e-7
   localparam logic [10:0] EXP_MAX_C  = 11'h7FF;

   typedef enum logic [0:0] {
      OP_MUL,
      OP_RECIP
   } fpu_op_type;

   typedef struct packed {
      logic       start;
      fpu_op_type op;
   } fpu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fpu_sts_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_PRE,
      F_DIV,
      F_NORM,
      F_SUB,
      F_ROUND
   } fpu_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SQ,
      S_SQ_W,
      S_MB,
      S_MB_W,
      S_POST,
      S_RCP_W,
      S_FIN
   } top_state_type;

endpackage

[rtl/dip_if.sv]
interface dip_req_if;
   logic               valid;
   logic               ready;
   logic        [63:0] base_value;
   logic signed [31:0] exponent_value;

   modport source (output valid, output base_value, output exponent_value, input ready);
   modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface dip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

[rtl/dip_fpu.sv]
`include "assert_macros.svh"

module dip_fpu import dip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fpu_ctl_type ctl,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   output fpu_sts_type sts,
   output logic [63:0] result
);

   fpu_state_type      state_ff, state_in;
   logic               sign_ff, sign_in;
   logic [52:0]        ma_ff, ma_in;
   logic [52:0]        mb_ff, mb_in;
   logic signed [13:0] er_ff, er_in;
   logic [105:0]       prod_ff, prod_in;
   logic [53:0]        rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        res_ff, res_in;
   logic               done_ff, done_in;

   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic [10:0] ea, eb;
   logic [52:0] mant_a, mant_b;
   logic [26:0] pp_x, pp_y;
   logic [53:0] pp;
   logic [105:0] pp_sh;
   logic        div_ge;
   logic [53:0] div_diff;
   logic [52:0] rnd_m;
   logic        rnd_inc;
   logic [53:0] rnd_mr;
   logic [52:0] rnd_mn;
   logic signed [13:0] rnd_en;
   logic [10:0] rnd_ef;

   always_comb begin
      nan_a  = (opa[62:52] == EXP_MAX_C) && (opa[51:0] != '0);
      nan_b  = (opb[62:52] == EXP_MAX_C) && (opb[51:0] != '0);
      inf_a  = (opa[62:52] == EXP_MAX_C) && (opa[51:0] == '0);
      inf_b  = (opb[62:52] == EXP_MAX_C) && (opb[51:0] == '0);
      zero_a = (opa[62:0] == '0);
      zero_b = (opb[62:0] == '0);
      ea     = (opa[62:52] == '0) ? 11'd1 : opa[62:52];
      eb     = (opb[62:52] == '0) ? 11'd1 : opb[62:52];
      mant_a = {(opa[62:52] != '0), opa[51:0]};
      mant_b = {(opb[62:52] != '0), opb[51:0]};

      pp_x = cnt_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
      pp_y = cnt_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];
      pp   = pp_x * pp_y;
      case (cnt_ff[1:0])
         2'd0:    pp_sh = {52'b0, pp};
         2'd3:    pp_sh = {pp[51:0], 54'b0};
         default: pp_sh = {25'b0, pp, 27'b0};
      endcase

      div_ge   = rem_ff >= {1'b0, ma_ff};
      div_diff = div_ge ? (rem_ff - {1'b0, ma_ff}) : rem_ff;

      rnd_m   = prod_ff[105:53];
      rnd_inc = prod_ff[52] & ((|prod_ff[51:0]) | rnd_m[0]);
      rnd_mr  = {1'b0, rnd_m} + {53'b0, rnd_inc};
      rnd_mn  = rnd_mr[53] ? rnd_mr[53:1] : rnd_mr[52:0];
      rnd_en  = er_ff + (rnd_mr[53] ? 14'sd1 : 14'sd0);
      rnd_ef  = rnd_mn[52] ? rnd_en[10:0] : 11'd0;
   end

   always_comb begin
      state_in = state_ff;
      sign_in  = sign_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      er_in    = er_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (ctl.start) begin
               if (ctl.op == OP_MUL) begin
                  sign_in = opa[63] ^ opb[63];
                  if (nan_a) begin
                     res_in = opa | QUIET_C;  done_in = 1'b1;
                  end else if (nan_b) begin
                     res_in = opb | QUIET_C;  done_in = 1'b1;
                  end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                     res_in = DEF_NAN_C;      done_in = 1'b1;
                  end else if (inf_a || inf_b) begin
                     res_in = {opa[63] ^ opb[63], POS_INF_C[62:0]};  done_in = 1'b1;
                  end else if (zero_a || zero_b) begin
                     res_in = {opa[63] ^ opb[63], 63'b0};  done_in = 1'b1;
                  end else begin
                     ma_in    = mant_a;
                     mb_in    = mant_b;
                     er_in    = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 14'sd1022;
                     prod_in  = '0;
                     cnt_in   = '0;
                     state_in = F_MUL;
                  end
               end else begin
                  sign_in = opa[63];
                  if (nan_a) begin
                     res_in = opa | QUIET_C;  done_in = 1'b1;
                  end else if (inf_a) begin
                     res_in = {opa[63], 63'b0};  done_in = 1'b1;
                  end else if (zero_a) begin
                     res_in = {opa[63], POS_INF_C[62:0]};  done_in = 1'b1;
                  end else begin
                     ma_in    = mant_a;
                     er_in    = $signed({3'b0, ea});
                     state_in = F_PRE;
                  end
               end
            end
         end
         F_MUL: begin
            prod_in = prod_ff + pp_sh;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = F_NORM;
            end
         end
         F_PRE: begin
            if (ma_ff[52]) begin
               er_in    = 14'sd2046 - er_ff;
               rem_in   = {2'b01, 52'b0};
               cnt_in   = '0;
               state_in = F_DIV;
            end else begin
               ma_in = {ma_ff[51:0], 1'b0};
               er_in = er_ff - 14'sd1;
            end
         end
         F_DIV: begin
            rem_in  = {div_diff[52:0], 1'b0};
            prod_in = {prod_ff[104:0], div_ge};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               prod_in  = {prod_ff[54:0], div_ge, 49'b0, (div_diff != '0)};
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            if (!prod_ff[105] && (er_ff > 14'sd1)) begin
               prod_in = {prod_ff[104:0], 1'b0};
               er_in   = er_ff - 14'sd1;
            end else begin
               state_in = F_SUB;
            end
         end
         F_SUB: begin
            if (er_ff < 14'sd1) begin
               if (er_ff < -14'sd56) begin
                  prod_in = {105'b0, (prod_ff != '0)};
                  er_in   = 14'sd1;
               end else begin
                  prod_in = {1'b0, prod_ff[105:2], prod_ff[1] | prod_ff[0]};
                  er_in   = er_ff + 14'sd1;
               end
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (rnd_en >= 14'sd2047) begin
               res_in = {sign_ff, POS_INF_C[62:0]};
            end else begin
               res_in = {sign_ff, rnd_ef, rnd_mn[51:0]};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sign_ff <= sign_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      er_ff   <= er_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign sts.busy = (state_ff != F_IDLE);
   assign sts.done = done_ff;
   assign result   = res_ff;

   `DIP_ASSERT_IMP(a_div_norm, clock, reset, state_ff == F_DIV, ma_ff[52], "divisor not normalized")
   `DIP_ASSERT_IMP(a_rnd_norm, clock, reset, state_ff == F_ROUND,
                   prod_ff[105] || (er_ff == 14'sd1), "round with unnormalized significand")
   `DIP_ASSERT_NXT(a_start_ack, clock, reset, ctl.start, sts.busy || sts.done,
                   "start neither taken nor answered")

endmodule

[rtl/double_integer_power.sv]
// Raises an IEEE double base to a signed 32-bit integer power by square and
// multiply, one item at a time; req_chan.ready is high only while the block is
// idle, and the result waits in an output register so the next item may enter.
// Zero exponent, exponent one and the small-base negative-exponent case go
// straight to the output without the double unit. Otherwise the exponent is
// scanned one bit a cycle from bit 31 to its top set bit, then each lower bit
// costs one squaring plus, if set, a multiply by the base, all on one shared
// double unit; a multiply forms four 27x27 partial products, then normalizes
// (with extra shifting when subnormals are involved) and rounds. A negative
// exponent adds a reciprocal (56-step restoring divide) unless the power is zero.
`include "assert_macros.svh"

module double_integer_power import dip_pkg::*; (
   input logic           clock,
   input logic           reset,
   dip_req_if.sink       req_chan,
   dip_rsp_if.source     rsp_chan
);

   top_state_type state_ff, state_in;
   logic [63:0]   base_ff, base_in;
   logic [63:0]   acc_ff, acc_in;
   logic [31:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [4:0]    idx_ff, idx_in;
   logic [63:0]   out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   fpu_ctl_type   fpu_ctl;
   fpu_sts_type   fpu_sts;
   logic [63:0]   fpu_opb;
   logic [63:0]   fpu_res;
   logic          small_base;
   logic [63:0]   in_base;
   logic [31:0]   in_exp;

   dip_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fpu_ctl),
      .opa    (acc_ff),
      .opb    (fpu_opb),
      .sts    (fpu_sts),
      .result (fpu_res)
   );

   assign fpu_opb = (state_ff == S_MB) ? base_ff : acc_ff;

   always_comb begin
      in_base    = req_chan.base_value;
      in_exp     = req_chan.exponent_value;
      small_base = in_base[63] ? (in_base[62:0] < NEG_LIM_C) : (in_base[62:0] < POS_LIM_C);

      state_in     = state_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      fpu_ctl.start = 1'b0;
      fpu_ctl.op    = OP_MUL;
      req_chan.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               base_in = in_base;
               neg_in  = in_exp[31];
               mag_in  = in_exp[31] ? (32'd0 - in_exp) : in_exp;
               idx_in  = 5'd31;
               if (in_exp[31] && small_base) begin
                  acc_in   = '0;
                  state_in = S_FIN;
               end else if (in_exp == 32'd0) begin
                  acc_in   = ONE_C;
                  state_in = S_FIN;
               end else if (in_exp == 32'd1) begin
                  acc_in   = in_base;
                  state_in = S_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            idx_in = idx_ff - 5'd1;
            if (mag_ff[idx_ff]) begin
               acc_in   = base_ff;
               state_in = (idx_ff == 5'd0) ? S_POST : S_SQ;
            end
         end
         S_SQ: begin
            fpu_ctl.start = 1'b1;
            state_in      = S_SQ_W;
         end
         S_SQ_W: begin
            if (fpu_sts.done) begin
               acc_in = fpu_res;
               if (mag_ff[idx_ff]) begin
                  state_in = S_MB;
               end else begin
                  idx_in   = idx_ff - 5'd1;
                  state_in = (idx_ff == 5'd0) ? S_POST : S_SQ;
               end
            end
         end
         S_MB: begin
            fpu_ctl.start = 1'b1;
            state_in      = S_MB_W;
         end
         S_MB_W: begin
            if (fpu_sts.done) begin
               acc_in   = fpu_res;
               idx_in   = idx_ff - 5'd1;
               state_in = (idx_ff == 5'd0) ? S_POST : S_SQ;
            end
         end
         S_POST: begin
            if (!neg_ff) begin
               state_in = S_FIN;
            end else if (acc_ff[62:0] == '0) begin
               acc_in   = {acc_ff[63], POS_INF_C[62:0]};
               state_in = S_FIN;
            end else begin
               fpu_ctl.start = 1'b1;
               fpu_ctl.op    = OP_RECIP;
               state_in      = S_RCP_W;
            end
         end
         S_RCP_W: begin
            if (fpu_sts.done) begin
               acc_in   = fpu_res;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = acc_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      base_ff <= base_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.power_result = out_ff;

   `DIP_ASSERT_IMP(a_fpu_free, clock, reset, fpu_ctl.start, !fpu_sts.busy,
                   "shared unit started while busy")
   `DIP_ASSERT_IMP(a_done_wait, clock, reset, fpu_sts.done,
                   (state_ff == S_SQ_W) || (state_ff == S_MB_W) || (state_ff == S_RCP_W),
                   "unit result with no waiting step")
   `DIP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready,
                   rsp_chan.valid && (rsp_chan.power_result == $past(rsp_chan.power_result)),
                   "result item changed while stalled")

endmodule
